>>> design/dlm_pkg.sv
`timescale 1ns / 1ps

package dlm_pkg;

    // store geometry
    localparam int MAX_INPUTS  = 256;
    localparam int MAX_OUTPUTS = 64;
    localparam int COL_W       = $clog2(MAX_INPUTS);
    localparam int ROW_W       = $clog2(MAX_OUTPUTS);

    // field widths
    localparam int DATA_W = 16;
    localparam int PROD_W = 32;
    localparam int ACC_W  = 48;
    localparam int OUT_W  = 32;
    localparam int FRAC_SHIFT = 14;

    // item kinds on the input stream
    localparam logic [1:0] MODE_WEIGHT = 2'd0;
    localparam logic [1:0] MODE_BIAS   = 2'd1;
    localparam logic [1:0] MODE_INPUT  = 2'd2;

    // configuration register indexes
    localparam logic [7:0] CFG_INPUT_COUNT  = 8'd0;
    localparam logic [7:0] CFG_OUTPUT_COUNT = 8'd1;

    // control tag that travels with each multiply-accumulate step
    typedef struct packed {
        logic valid;
        logic first;
    } t_mac_ctl;

endpackage

>>> design/dense_layer_matvec_core.sv
`timescale 1ns / 1ps

// Fully connected layer core. Weight, bias and input items are written into
// on-chip memories at one item per cycle while idle. The input item whose
// column equals input_count-1 starts the matrix-vector product: one
// multiply-accumulate per cycle through a single shared MAC, reading the
// weight and input memories at one address each cycle. No input item is
// taken until the last output neuron has been emitted. Results leave
// through an output register; a stalled result holds the sequencer at the
// end of its row.
module dense_layer_matvec_core
    import dlm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // row[5:0], col[13:6], value[29:14], zero pad
    input  logic [1:0]  s_axis_tuser,   // mode
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // out_index[5:0], out_value[37:6], zero pad
    output logic        m_axis_tlast
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ISSUE = 3'b010,
        ST_EMIT  = 3'b100
    } t_state;

    t_state r_state, n_state;

    // count registers, kept as last index in use
    logic [COL_W-1:0] r_last_col;
    logic [ROW_W-1:0] r_last_row;

    // memories
    logic [DATA_W-1:0] weight_mem [MAX_OUTPUTS*MAX_INPUTS];
    logic [DATA_W-1:0] bias_mem   [MAX_OUTPUTS];
    logic [DATA_W-1:0] input_mem  [MAX_INPUTS];

    logic [DATA_W-1:0] r_w_q, r_x_q, r_b_q;

    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    t_mac_ctl          r_ctl1;
    t_mac_ctl          w_ctl0;

    logic              w_in_acc;
    logic [1:0]        w_mode;
    logic [ROW_W-1:0]  w_in_row;
    logic [COL_W-1:0]  w_in_col;
    logic [DATA_W-1:0] w_in_value;

    logic              w_mac_busy;
    logic signed [OUT_W-1:0] w_result;
    logic              w_emit;

    logic              r_out_valid;
    logic [ROW_W-1:0]  r_out_index;
    logic [OUT_W-1:0]  r_out_value;
    logic              r_out_last;

    // input item fields
    assign w_mode     = s_axis_tuser;
    assign w_in_row   = s_axis_tdata[ROW_W-1:0];
    assign w_in_col   = s_axis_tdata[ROW_W+COL_W-1:ROW_W];
    assign w_in_value = s_axis_tdata[ROW_W+COL_W+DATA_W-1:ROW_W+COL_W];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // configuration, zero acts as one and large values saturate; the output count uses only its low seven bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_col <= '0;
            r_last_row <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_INPUT_COUNT) begin
                if (i_cfg_data == '0) begin
                    r_last_col <= '0;
                end else if (i_cfg_data > 9'(MAX_INPUTS)) begin
                    r_last_col <= COL_W'(MAX_INPUTS - 1);
                end else begin
                    r_last_col <= COL_W'(i_cfg_data - 9'd1);
                end
            end else if (i_cfg_index == CFG_OUTPUT_COUNT) begin
                if (i_cfg_data[6:0] == '0) begin
                    r_last_row <= '0;
                end else if (i_cfg_data[6:0] > 7'(MAX_OUTPUTS)) begin
                    r_last_row <= ROW_W'(MAX_OUTPUTS - 1);
                end else begin
                    r_last_row <= ROW_W'(i_cfg_data[6:0] - 7'd1);
                end
            end
        end
    end

    // memory writes from the input stream, reads from the sequencer
    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_mode == MODE_WEIGHT) begin
            weight_mem[{w_in_row, w_in_col}] <= w_in_value;
        end
        r_w_q <= weight_mem[{r_row, r_col}];
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_mode == MODE_BIAS) begin
            bias_mem[w_in_row] <= w_in_value;
        end
        r_b_q <= bias_mem[r_row];
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_mode == MODE_INPUT) begin
            input_mem[w_in_col] <= w_in_value;
        end
        r_x_q <= input_mem[r_col];
    end

    // tag for the read issued this cycle
    assign w_ctl0.valid = (r_state == ST_ISSUE);
    assign w_ctl0.first = (r_col == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
        end else begin
            r_ctl1 <= w_ctl0;
        end
    end

    dlm_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (r_ctl1),
        .i_weight (r_w_q),
        .i_x      (r_x_q),
        .i_bias   (r_b_q),
        .o_busy   (w_mac_busy),
        .o_result (w_result)
    );

    // row result is ready once the pipeline has drained
    assign w_emit = (r_state == ST_EMIT) && !r_ctl1.valid && !w_mac_busy
                    && (!r_out_valid || m_axis_tready);

    // sequencer
    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_col   = r_col;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc && w_mode == MODE_INPUT && w_in_col == r_last_col) begin
                    n_state = ST_ISSUE;
                    n_row   = '0;
                    n_col   = '0;
                end
            end
            ST_ISSUE: begin
                if (r_col == r_last_col) begin
                    n_state = ST_EMIT;
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
            ST_EMIT: begin
                if (w_emit) begin
                    n_col = '0;
                    if (r_row == r_last_row) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_ISSUE;
                        n_row   = r_row + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_row   <= '0;
            r_col   <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_index <= r_row;
            r_out_value <= w_result;
            r_out_last  <= (r_row == r_last_row);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_value, r_out_index};
    assign m_axis_tlast  = r_out_last;

endmodule

>>> design/dlm_mac.sv
`timescale 1ns / 1ps

module dlm_mac
    import dlm_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_mac_ctl                 i_ctl,
    input  logic signed [DATA_W-1:0] i_weight,
    input  logic signed [DATA_W-1:0] i_x,
    input  logic signed [DATA_W-1:0] i_bias,
    output logic                     o_busy,
    output logic signed [OUT_W-1:0]  o_result
);

    localparam int SH_W = ACC_W - FRAC_SHIFT;

    t_mac_ctl                  r_ctl;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [DATA_W-1:0]  r_bias;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [ACC_W-1:0]   n_acc;
    logic signed [ACC_W-1:0]   w_base;
    logic signed [SH_W-1:0]    w_sh;

    // product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
        r_prod <= i_weight * i_x;
        r_bias <= i_bias;
    end

    // accumulate, the first step of a row starts from the bias
    always_comb begin
        w_base = r_ctl.first ? (ACC_W'(r_bias) <<< FRAC_SHIFT) : r_acc;
        n_acc  = w_base + ACC_W'(r_prod);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (r_ctl.valid) begin
            r_acc <= n_acc;
        end
    end

    // floor shift back to Q24.8 and saturate to 32 bits
    assign w_sh = SH_W'(r_acc >>> FRAC_SHIFT);

    always_comb begin
        if (w_sh[SH_W-1] == 1'b0 && w_sh[SH_W-2:OUT_W-1] != '0) begin
            o_result = {1'b0, {(OUT_W-1){1'b1}}};
        end else if (w_sh[SH_W-1] == 1'b1 && w_sh[SH_W-2:OUT_W-1] != '1) begin
            o_result = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            o_result = w_sh[OUT_W-1:0];
        end
    end

    assign o_busy = r_ctl.valid;

endmodule

>>> sim/tb_dense_layer_matvec_core.sv
`timescale 1ns / 1ps

module tb_dense_layer_matvec_core;
    import dlm_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 32;
    localparam int HOLD_CYCLES = 400;
    localparam longint CYCLE_LIMIT = 1_000_000;
    localparam longint OUT_MAX = 64'sd2147483647;
    localparam longint OUT_MIN = -64'sd2147483648;

    typedef struct packed {
        logic [5:0]  index;
        logic [31:0] value;
        logic        last;
    } t_neuron;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index = '0;
    logic [8:0]  i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // row[5:0], col[13:6], value[29:14], zero pad
    logic [1:0]  s_axis_tuser = '0;   // mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // out_index[5:0], out_value[37:6], zero pad
    logic        m_axis_tlast;

    // shadow of the layer memories and count registers
    logic [15:0] wt_mem [MAX_OUTPUTS][MAX_INPUTS];
    logic [15:0] bias_mem [MAX_OUTPUTS];
    logic [15:0] vec_mem [MAX_INPUTS];
    bit          wt_set [MAX_OUTPUTS][MAX_INPUTS];
    bit          bias_set [MAX_OUTPUTS];
    bit          vec_set [MAX_INPUTS];
    logic [8:0]  cfg_in = 9'd1;
    logic [6:0]  cfg_out = 7'd1;

    t_neuron     pending_neurons[$];

    int          snd_idle_pct = 0;
    int          rcv_stall_pct = 0;
    bit          rcv_hold = 1'b0;
    event        hold_ev;
    int          item_cnt = 0;
    int          checked_cnt = 0;
    int          mismatch_cnt = 0;
    int          settings_cnt = 0;
    longint      cycle_cnt = 0;

    dense_layer_matvec_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
                     pending_neurons.size());
            $display("FAIL");
            $finish;
        end
    end

    // effective counts: zero acts as one, large values clip to the memory size
    function automatic int active_inputs();
        if (cfg_in == 0) return 1;
        if (cfg_in > MAX_INPUTS) return MAX_INPUTS;
        return int'(cfg_in);
    endfunction

    function automatic int active_outputs();
        if (cfg_out == 0) return 1;
        if (cfg_out > MAX_OUTPUTS) return MAX_OUTPUTS;
        return int'(cfg_out);
    endfunction

    // update memories and queue the neuron outputs a vector completion produces
    function automatic void predict_layer_item(input logic [1:0] mode, input logic [5:0] row,
                                               input logic [7:0] col, input logic [15:0] value);
        logic [47:0] acc;
        longint      sum;
        longint      q;
        t_neuron     r;
        int          n_in;
        int          n_out;
        n_in = active_inputs();
        n_out = active_outputs();
        case (mode)
            MODE_WEIGHT: begin
                wt_mem[row][col] = value;
                wt_set[row][col] = 1'b1;
            end
            MODE_BIAS: begin
                bias_mem[row] = value;
                bias_set[row] = 1'b1;
            end
            MODE_INPUT: begin
                vec_mem[col] = value;
                vec_set[col] = 1'b1;
                if (int'(col) == n_in - 1) begin
                    for (int k = 0; k < n_out; k++) begin
                        // bias aligned to the Q10.22 products, 48-bit wrap
                        acc = 48'(longint'($signed(bias_mem[k])) <<< FRAC_SHIFT);
                        for (int i = 0; i < n_in; i++) begin
                            acc = acc + 48'(longint'($signed(wt_mem[k][i]))
                                            * longint'($signed(vec_mem[i])));
                        end
                        sum = longint'($signed(acc));
                        q = sum >>> FRAC_SHIFT;
                        if (q > OUT_MAX) q = OUT_MAX;
                        if (q < OUT_MIN) q = OUT_MIN;
                        r.index = 6'(k);
                        r.value = q[31:0];
                        r.last = (k == n_out - 1);
                        pending_neurons = {pending_neurons, r};
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // output stream ready, random stalls plus an optional long hold
    always @(posedge i_clk) begin
        m_axis_tready <= !rcv_hold && ($urandom_range(0, 99) >= rcv_stall_pct);
    end

    // long receiver hold, counted in cycles
    initial begin
        forever begin
            @(hold_ev);
            rcv_hold = 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            rcv_hold = 1'b0;
        end
    end

    // compare each accepted result with the oldest expected neuron
    always @(posedge i_clk) begin
        t_neuron want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_neurons.size() == 0) begin
                $display("%0t: unexpected result, index %0d value %0d last %0b", $time,
                         m_axis_tdata[5:0], $signed(m_axis_tdata[37:6]), m_axis_tlast);
                mismatch_cnt++;
            end else begin
                want = pending_neurons.pop_front();
                checked_cnt++;
                if (m_axis_tdata[5:0] !== want.index) begin
                    $display("%0t: out_index expected %0d actual %0d", $time, want.index,
                             m_axis_tdata[5:0]);
                    mismatch_cnt++;
                end
                if (m_axis_tdata[37:6] !== want.value) begin
                    $display("%0t: out_value (neuron %0d) expected %0d actual %0d", $time,
                             want.index, $signed(want.value), $signed(m_axis_tdata[37:6]));
                    mismatch_cnt++;
                end
                if (m_axis_tlast !== want.last) begin
                    $display("%0t: last (neuron %0d) expected %0b actual %0b", $time,
                             want.index, want.last, m_axis_tlast);
                    mismatch_cnt++;
                end
            end
        end
    end

    // offer one item, with random idle cycles first
    task automatic send_item(input logic [1:0] mode, input logic [5:0] row,
                             input logic [7:0] col, input logic [15:0] value);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, value, col, row};
        s_axis_tuser <= mode;
        do @(posedge i_clk); while (!s_axis_tready);
        if (mode != MODE_UNUSED) item_cnt++;
        predict_layer_item(mode, row, col, value);
    endtask

    // stop offering, wait for all outputs, then let the core settle
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_neurons.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write both count registers back to back
    task automatic set_counts(input logic [8:0] in_val, input logic [8:0] out_val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_INPUT_COUNT;
        i_cfg_data <= in_val;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_in = in_val;
        i_cfg_index <= CFG_OUTPUT_COUNT;
        i_cfg_data <= out_val;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_out = out_val[6:0];
        i_cfg_valid <= 1'b0;
        settings_cnt++;
    endtask

    // fill every memory entry the current sizes will read and that is still unwritten, but for the last vector element
    task automatic load_missing();
        int n_in;
        int n_out;
        n_in = active_inputs();
        n_out = active_outputs();
        for (int k = 0; k < n_out; k++) begin
            if (!bias_set[k]) send_item(MODE_BIAS, 6'(k), 8'($urandom), 16'($urandom));
            for (int i = 0; i < n_in; i++) begin
                if (!wt_set[k][i]) send_item(MODE_WEIGHT, 6'(k), 8'(i), 16'($urandom));
            end
        end
        for (int i = 0; i < n_in - 1; i++) begin
            if (!vec_set[i]) send_item(MODE_INPUT, 6'($urandom), 8'(i), 16'($urandom));
        end
    endtask

    // some vector elements in any order, closed by the last element
    task automatic send_vector();
        int n_in;
        n_in = active_inputs();
        if (n_in > 1) begin
            repeat ($urandom_range(0, n_in + 2))
                send_item(MODE_INPUT, 6'($urandom), 8'($urandom_range(0, n_in - 2)),
                          16'($urandom));
        end
        send_item(MODE_INPUT, 6'($urandom), 8'(n_in - 1), 16'($urandom));
    endtask

    // one by one layer after reset: value extremes, rounding, unused mode, top indexes
    task automatic test_directed();
        snd_idle_pct = 0;
        rcv_stall_pct = 0;
        send_item(MODE_WEIGHT, 6'd0, 8'd0, 16'h8000);
        send_item(MODE_BIAS, 6'd0, 8'd0, 16'h7FFF);
        send_item(MODE_INPUT, 6'd0, 8'd0, 16'h8000);
        send_item(MODE_INPUT, 6'd0, 8'd0, 16'h7FFF);
        send_item(MODE_WEIGHT, 6'd0, 8'd0, 16'h7FFF);
        send_item(MODE_BIAS, 6'd0, 8'd0, 16'h8000);
        send_item(MODE_INPUT, 6'd0, 8'd0, 16'h8000);
        // negative sum below one lsb rounds toward minus infinity
        send_item(MODE_WEIGHT, 6'd0, 8'd0, 16'hFFFF);
        send_item(MODE_BIAS, 6'd0, 8'd0, 16'h0000);
        send_item(MODE_INPUT, 6'd0, 8'd0, 16'h0001);
        send_item(MODE_INPUT, 6'd0, 8'd0, 16'h0000);
        // unused mode on the closing column produces nothing
        send_item(MODE_UNUSED, 6'd0, 8'd0, 16'h1234);
        // top row and column, no vector completion at this size
        send_item(MODE_WEIGHT, 6'd63, 8'd255, 16'h5A5A);
        send_item(MODE_BIAS, 6'd63, 8'd255, 16'hA5A5);
        send_item(MODE_INPUT, 6'd63, 8'd255, 16'h7FFF);
        // plain 1.0 * 2.5 + 1.0
        send_item(MODE_WEIGHT, 6'd0, 8'd0, 16'h4000);
        send_item(MODE_BIAS, 6'd0, 8'd0, 16'h0100);
        send_item(MODE_INPUT, 6'd0, 8'd0, 16'h0280);
    endtask

    // both counts at zero, output count at its bound and beyond it
    task automatic test_count_limits();
        logic [8:0] in_vals [4] = '{9'd0, 9'd1, 9'd1, 9'd0};
        logic [8:0] out_vals [4] = '{9'd0, 9'd64, 9'd100, 9'd128};
        snd_idle_pct = 0;
        rcv_stall_pct = 0;
        for (int s = 0; s < 4; s++) begin
            wait_idle();
            set_counts(in_vals[s], out_vals[s]);
            load_missing();
            send_vector();
        end
    endtask

    // mostly complete vectors with weight and bias updates, plus noise
    task automatic test_random_traffic(input int snd_pct, input int rcv_pct, input int n_items);
        int stop_at;
        int n_in;
        int n_out;
        snd_idle_pct = snd_pct;
        rcv_stall_pct = rcv_pct;
        repeat (2) begin
            wait_idle();
            set_counts(9'($urandom_range(1, 2)), 9'($urandom_range(1, 4)));
            load_missing();
            n_in = active_inputs();
            n_out = active_outputs();
            stop_at = item_cnt + n_items / 2;
            while (item_cnt < stop_at) begin
                case ($urandom_range(0, 9))
                    7: send_item(2'($urandom), 6'($urandom), 8'($urandom), 16'($urandom));
                    8: begin
                        // partial vector, never closed
                        if (n_in > 1)
                            repeat ($urandom_range(1, 3))
                                send_item(MODE_INPUT, 6'($urandom),
                                          8'($urandom_range(0, n_in - 2)), 16'($urandom));
                        else
                            send_item(MODE_BIAS, 6'($urandom), 8'($urandom), 16'($urandom));
                    end
                    9: send_item(MODE_UNUSED, 6'($urandom), 8'(n_in - 1), 16'($urandom));
                    default: begin
                        repeat ($urandom_range(0, 2))
                            send_item(MODE_WEIGHT, 6'($urandom_range(0, n_out - 1)),
                                      8'($urandom_range(0, n_in - 1)), 16'($urandom));
                        if ($urandom_range(0, 1))
                            send_item(MODE_BIAS, 6'($urandom_range(0, n_out - 1)),
                                      8'($urandom), 16'($urandom));
                        send_vector();
                    end
                endcase
            end
        end
    endtask

    // output held off for a long time while vectors keep coming
    task automatic test_backpressure();
        wait_idle();
        snd_idle_pct = 0;
        rcv_stall_pct = 0;
        set_counts(9'd1, 9'd64);
        load_missing();
        -> hold_ev;
        repeat (4) send_vector();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_count_limits();
        test_random_traffic(0, 0, 8);
        test_random_traffic(49, 0, 8);
        test_random_traffic(0, 49, 8);
        test_random_traffic(7, 7, 8);
        test_backpressure();
        wait_idle();
        $display("covered %0d stream items over %0d count settings, incl. idle, stall and hold",
                 item_cnt, settings_cnt);
        $display("%0d neuron outputs checked, %0d mismatches", checked_cnt, mismatch_cnt);
        if (mismatch_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
